/* rtl/core/nqe_pkg.sv */
// nqe_pkg: shared types, constants and the control store of the n-queens enumerator
`timescale 1ns / 1ps

package nqe_pkg;

   localparam logic [5:0] BOARD_SIZE_RESET = 6'd18;

   typedef logic [4:0] step_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_CLEAR,
      OP_ROW_ZERO,
      OP_DEC_READ,
      OP_UNPLACE,
      OP_ROW_INC,
      OP_PLACE,
      OP_SET_DONE,
      OP_EMIT_FIRST,
      OP_EMIT,
      OP_EMIT_EXH
   } op_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_START,
      COND_NO_RESTART,
      COND_DONE,
      COND_DEPTH_LT_N,
      COND_DEPTH_GE_N,
      COND_ROW_GE_N,
      COND_ROW_FREE,
      COND_DEPTH_ZERO,
      COND_COL_NOT_LAST
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctl_word_type;

   typedef struct packed {
      logic restart;
      logic done;
      logic depth_ge_n;
      logic depth_zero;
      logic row_ge_n;
      logic row_free;
      logic col_last;
   } status_type;

   localparam step_type S_IDLE       = 5'd0;
   localparam step_type S_CHK_RST    = 5'd1;
   localparam step_type S_CLEAR      = 5'd2;
   localparam step_type S_CHK_DONE   = 5'd3;
   localparam step_type S_CHK_RESUME = 5'd4;
   localparam step_type S_RES_READ   = 5'd5;
   localparam step_type S_RES_LIFT   = 5'd6;
   localparam step_type S_TRY        = 5'd7;
   localparam step_type S_TEST       = 5'd8;
   localparam step_type S_NEXT_ROW   = 5'd9;
   localparam step_type S_PLACE      = 5'd10;
   localparam step_type S_CHK_FULL   = 5'd11;
   localparam step_type S_LOOP       = 5'd12;
   localparam step_type S_BACK       = 5'd13;
   localparam step_type S_BACK_READ  = 5'd14;
   localparam step_type S_BACK_LIFT  = 5'd15;
   localparam step_type S_FINISH     = 5'd16;
   localparam step_type S_EMIT_FIRST = 5'd17;
   localparam step_type S_EMIT       = 5'd18;
   localparam step_type S_EMIT_END   = 5'd19;
   localparam step_type S_EXH        = 5'd20;

   function automatic ctl_word_type ucode(input step_type s);
      ctl_word_type w;
      unique case (s)
         S_IDLE:       w = '{OP_ACCEPT,     COND_NO_START,     S_IDLE};
         S_CHK_RST:    w = '{OP_NONE,       COND_NO_RESTART,   S_CHK_DONE};
         S_CLEAR:      w = '{OP_CLEAR,      COND_NEVER,        S_IDLE};
         S_CHK_DONE:   w = '{OP_NONE,       COND_DONE,         S_EXH};
         S_CHK_RESUME: w = '{OP_ROW_ZERO,   COND_DEPTH_LT_N,   S_TRY};
         S_RES_READ:   w = '{OP_DEC_READ,   COND_NEVER,        S_IDLE};
         S_RES_LIFT:   w = '{OP_UNPLACE,    COND_ALWAYS,       S_TRY};
         S_TRY:        w = '{OP_NONE,       COND_ROW_GE_N,     S_BACK};
         S_TEST:       w = '{OP_NONE,       COND_ROW_FREE,     S_PLACE};
         S_NEXT_ROW:   w = '{OP_ROW_INC,    COND_ALWAYS,       S_TRY};
         S_PLACE:      w = '{OP_PLACE,      COND_NEVER,        S_IDLE};
         S_CHK_FULL:   w = '{OP_NONE,       COND_DEPTH_GE_N,   S_EMIT_FIRST};
         S_LOOP:       w = '{OP_NONE,       COND_ALWAYS,       S_TRY};
         S_BACK:       w = '{OP_NONE,       COND_DEPTH_ZERO,   S_FINISH};
         S_BACK_READ:  w = '{OP_DEC_READ,   COND_NEVER,        S_IDLE};
         S_BACK_LIFT:  w = '{OP_UNPLACE,    COND_ALWAYS,       S_TRY};
         S_FINISH:     w = '{OP_SET_DONE,   COND_ALWAYS,       S_EXH};
         S_EMIT_FIRST: w = '{OP_EMIT_FIRST, COND_NEVER,        S_IDLE};
         S_EMIT:       w = '{OP_EMIT,       COND_COL_NOT_LAST, S_EMIT};
         S_EMIT_END:   w = '{OP_NONE,       COND_ALWAYS,       S_IDLE};
         S_EXH:        w = '{OP_EMIT_EXH,   COND_ALWAYS,       S_IDLE};
         default:      w = '{OP_NONE,       COND_ALWAYS,       S_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/nqe_sequencer.sv */
// nqe_sequencer: step counter, control store lookup and conditional jumps
`timescale 1ns / 1ps

module nqe_sequencer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  nqe_pkg::status_type  status,
   output nqe_pkg::ctl_word_type ctl,
   output logic                 busy
);
   import nqe_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     take_jump;

   always_comb begin
      ctl = ucode(step_ff);
   end

   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:        take_jump = 1'b0;
         COND_ALWAYS:       take_jump = 1'b1;
         COND_NO_START:     take_jump = !start;
         COND_NO_RESTART:   take_jump = !status.restart;
         COND_DONE:         take_jump = status.done;
         COND_DEPTH_LT_N:   take_jump = !status.depth_ge_n;
         COND_DEPTH_GE_N:   take_jump = status.depth_ge_n;
         COND_ROW_GE_N:     take_jump = status.row_ge_n;
         COND_ROW_FREE:     take_jump = status.row_free;
         COND_DEPTH_ZERO:   take_jump = status.depth_zero;
         COND_COL_NOT_LAST: take_jump = !status.col_last;
         default:           take_jump = 1'b0;
      endcase
   end

   always_comb begin
      if (take_jump) begin
         step_in = ctl.target;
      end else begin
         step_in = step_ff + step_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign busy = (step_ff != S_IDLE);

endmodule

/* rtl/core/nqe_datapath.sv */
// nqe_datapath: board size register, occupancy masks, placed-row memory and result beat register
`timescale 1ns / 1ps

module nqe_datapath #(
   parameter int MAX_BOARD = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [5:0]            csr_wr_data,
   input  logic                  req_restart,
   input  nqe_pkg::ctl_word_type ctl,
   output nqe_pkg::status_type   status,
   output logic                  rsp_valid,
   output logic [4:0]            rsp_column,
   output logic [4:0]            rsp_queen_row,
   output logic                  rsp_last,
   output logic                  rsp_exhausted
);
   import nqe_pkg::*;

   localparam int RW  = $clog2(MAX_BOARD);
   localparam int NW  = $clog2(MAX_BOARD + 1);
   localparam int DW  = 2 * MAX_BOARD - 1;
   localparam int DIW = $clog2(DW);

   logic [5:0]           bs_ff, bs_in;
   logic                 restart_ff, restart_in;
   logic                 done_ff, done_in;
   logic [NW-1:0]        depth_ff, depth_in;
   logic [NW-1:0]        row_ff, row_in;
   logic [RW-1:0]        col_ff, col_in;
   logic [MAX_BOARD-1:0] row_mask_ff, row_mask_in;
   logic [DW-1:0]        up_mask_ff, up_mask_in;
   logic [DW-1:0]        dn_mask_ff, dn_mask_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [4:0]           rsp_column_ff, rsp_column_in;
   logic [4:0]           rsp_queen_row_ff, rsp_queen_row_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_exhausted_ff, rsp_exhausted_in;

   logic [RW-1:0]        placed_mem [MAX_BOARD];
   logic [RW-1:0]        rd_ff;
   logic [RW-1:0]        rd_addr;

   logic [NW-1:0]        n_val;
   logic [RW-1:0]        chk_row;
   logic [RW-1:0]        chk_col;
   logic [DIW-1:0]       up_idx;
   logic [DIW-1:0]       dn_idx;
   logic                 col_last;

   // effective board size, clamped to 1..MAX_BOARD
   always_comb begin
      if (bs_ff == 6'd0) begin
         n_val = NW'(1);
      end else if (int'(bs_ff) > MAX_BOARD) begin
         n_val = NW'(MAX_BOARD);
      end else begin
         n_val = NW'(bs_ff);
      end
   end

   always_comb begin
      chk_row = (ctl.op == OP_UNPLACE) ? rd_ff : row_ff[RW-1:0];
      chk_col = depth_ff[RW-1:0];
      up_idx  = DIW'(chk_row) + DIW'(chk_col);
      dn_idx  = DIW'(chk_row) + DIW'(MAX_BOARD - 1) - DIW'(chk_col);
      col_last = (NW'(col_ff) == n_val - NW'(1));
   end

   always_comb begin
      status.restart    = restart_ff;
      status.done       = done_ff;
      status.depth_ge_n = (depth_ff >= n_val);
      status.depth_zero = (depth_ff == '0);
      status.row_ge_n   = (row_ff >= n_val);
      status.row_free   = !row_mask_ff[chk_row] && !up_mask_ff[up_idx] && !dn_mask_ff[dn_idx];
      status.col_last   = col_last;
   end

   always_comb begin
      unique case (ctl.op)
         OP_DEC_READ: rd_addr = depth_ff[RW-1:0] - RW'(1);
         OP_EMIT:     rd_addr = col_ff + RW'(1);
         default:     rd_addr = '0;
      endcase
   end

   always_comb begin
      bs_in            = bs_ff;
      restart_in       = restart_ff;
      done_in          = done_ff;
      depth_in         = depth_ff;
      row_in           = row_ff;
      col_in           = col_ff;
      row_mask_in      = row_mask_ff;
      up_mask_in       = up_mask_ff;
      dn_mask_in       = dn_mask_ff;
      rsp_valid_in     = 1'b0;
      rsp_column_in    = 5'd0;
      rsp_queen_row_in = 5'd0;
      rsp_last_in      = 1'b0;
      rsp_exhausted_in = 1'b0;
      if (csr_wr_en) begin
         bs_in       = csr_wr_data;
         done_in     = 1'b0;
         depth_in    = '0;
         row_mask_in = '0;
         up_mask_in  = '0;
         dn_mask_in  = '0;
      end else begin
         unique case (ctl.op)
            OP_ACCEPT: begin
               restart_in = req_restart;
            end
            OP_CLEAR: begin
               done_in     = 1'b0;
               depth_in    = '0;
               row_mask_in = '0;
               up_mask_in  = '0;
               dn_mask_in  = '0;
            end
            OP_ROW_ZERO: begin
               row_in = '0;
            end
            OP_DEC_READ: begin
               depth_in = depth_ff - NW'(1);
            end
            OP_UNPLACE: begin
               row_mask_in = row_mask_ff ^ (MAX_BOARD'(1) << chk_row);
               up_mask_in  = up_mask_ff ^ (DW'(1) << up_idx);
               dn_mask_in  = dn_mask_ff ^ (DW'(1) << dn_idx);
               row_in      = NW'(rd_ff) + NW'(1);
            end
            OP_ROW_INC: begin
               row_in = row_ff + NW'(1);
            end
            OP_PLACE: begin
               row_mask_in = row_mask_ff ^ (MAX_BOARD'(1) << chk_row);
               up_mask_in  = up_mask_ff ^ (DW'(1) << up_idx);
               dn_mask_in  = dn_mask_ff ^ (DW'(1) << dn_idx);
               depth_in    = depth_ff + NW'(1);
               row_in      = '0;
            end
            OP_SET_DONE: begin
               done_in = 1'b1;
            end
            OP_EMIT_FIRST: begin
               col_in = '0;
            end
            OP_EMIT: begin
               rsp_valid_in     = 1'b1;
               rsp_column_in    = 5'(col_ff);
               rsp_queen_row_in = 5'(rd_ff);
               rsp_last_in      = col_last;
               col_in           = col_ff + RW'(1);
            end
            OP_EMIT_EXH: begin
               rsp_valid_in     = 1'b1;
               rsp_exhausted_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff        <= BOARD_SIZE_RESET;
         restart_ff   <= 1'b0;
         done_ff      <= 1'b0;
         depth_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         row_mask_ff  <= '0;
         up_mask_ff   <= '0;
         dn_mask_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bs_ff        <= bs_in;
         restart_ff   <= restart_in;
         done_ff      <= done_in;
         depth_ff     <= depth_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         row_mask_ff  <= row_mask_in;
         up_mask_ff   <= up_mask_in;
         dn_mask_ff   <= dn_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_column_ff    <= rsp_column_in;
      rsp_queen_row_ff <= rsp_queen_row_in;
      rsp_last_ff      <= rsp_last_in;
      rsp_exhausted_ff <= rsp_exhausted_in;
   end

   // placed-row memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.op == OP_PLACE && !csr_wr_en) begin
         placed_mem[depth_ff[RW-1:0]] <= row_ff[RW-1:0];
      end
      rd_ff <= placed_mem[rd_addr];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_column    = rsp_column_ff;
   assign rsp_queen_row = rsp_queen_row_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_exhausted = rsp_exhausted_ff;

endmodule

/* rtl/core/n_queens_enumerator.sv */
// n_queens_enumerator: top level of the microcoded n-queens backtracking enumerator
`timescale 1ns / 1ps

// Each request (start while busy is low) runs the column-by-column backtracking
// search to the next solution and then sends it as one beat per column on the
// rsp_ ports, each beat held for exactly one cycle with rsp_valid high; the
// receiver cannot stall, so every beat must be captured when it appears. When
// the search is exhausted a single beat with rsp_exhausted set is sent. A
// request runs for a data-dependent time: the sequencer takes one control
// store step per cycle and the safety test checks one row per step. The last
// beat of a request may still be on the outputs in the first cycle busy is low.
// Write board_size only while busy is low; a write also clears the search.
module n_queens_enumerator #(
   parameter int MAX_BOARD = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_restart,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data,
   output logic       rsp_valid,
   output logic [4:0] rsp_column,
   output logic [4:0] rsp_queen_row,
   output logic       rsp_last,
   output logic       rsp_exhausted
);
   import nqe_pkg::*;

   ctl_word_type ctl;
   status_type   status;

   nqe_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctl    (ctl),
      .busy   (busy)
   );

   nqe_datapath #(
      .MAX_BOARD (MAX_BOARD)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_restart   (req_restart),
      .ctl           (ctl),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_column    (rsp_column),
      .rsp_queen_row (rsp_queen_row),
      .rsp_last      (rsp_last),
      .rsp_exhausted (rsp_exhausted)
   );

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   a_exhausted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exhausted |-> rsp_column == 5'd0 && rsp_queen_row == 5'd0 && !rsp_last)
      else $error("exhausted beat carries nonzero fields");

   a_columns_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_exhausted && !rsp_last |=>
         rsp_valid && !rsp_exhausted && rsp_column == $past(rsp_column) + 5'd1)
      else $error("solution beats not consecutive columns");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_last || rsp_exhausted) |=> !rsp_valid)
      else $error("beat follows the final beat of a request");

endmodule
